// ----- rtl/core/rlcu_pkg.sv -----
// Shared constants for the ring log chunk uploader: default sizes,
// result kinds, command codes and request modes. No dependencies.
package rlcu_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned CHUNK_DEF    = 16;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_LOST   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_PING = 2'd0,
		CMD_SEEK = 2'd1,
		CMD_ACK  = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_POLL   = 1'b1;

endpackage

// ----- rtl/core/ring_log_chunk_uploader.sv -----
// Ring log chunk uploader: byte ring in one synchronous RAM plus the
// poll/command sequencer and a one-deep result register.
// Depends on rlcu_pkg.
//
// An append is taken without leaving idle, and a request may follow at once.
// A poll is accepted, answered with a command status if it carries a command,
// then evaluated; a chunk then streams its bytes (RAM read pipelined one
// ahead), followed by a closing status if the chunk reaches the write head.
// Results leave through a registered output; a stalled consumer holds the
// sequencer. Reset (arst_n low, asynchronous) clears all counters and flags;
// the ring RAM is not cleared and needs no clearing pass.
module ring_log_chunk_uploader #(
	parameter int unsigned CAPACITY = rlcu_pkg::CAPACITY_DEF,
	parameter int unsigned CHUNK    = rlcu_pkg::CHUNK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        link_up,
	input  logic        command_valid,
	input  logic [1:0]  command,
	input  logic [31:0] argument,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] frame_offset,
	output logic [7:0]  payload_byte,
	output logic        last,
	output logic        more_pending,
	output logic [31:0] total_bytes,
	output logic [31:0] oldest_offset,
	output logic [31:0] confirmed_offset
);
	import rlcu_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CHUNK + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOST,
		S_CMDST,
		S_EVAL,
		S_DATA,
		S_TAIL
	} state_t;

	state_t state_q;

	// architectural state
	logic [31:0]   wc_q;        // total bytes appended
	logic [AW-1:0] wptr_q;      // wc_q mod CAPACITY
	logic [31:0]   cursor_q;
	logic [31:0]   conf_q;
	logic          sending_q;
	logic          conn_q;

	// chunk walk
	logic [31:0]   start_q;
	logic [CW-1:0] cnt_q;       // bytes still to emit, incl. the one in rdata_q
	logic [AW-1:0] addr_q;      // RAM address of the byte in rdata_q
	logic          tail_q;      // chunk reaches the write head: status follows

	// ring RAM
	logic [7:0]    ring_mem [CAPACITY];
	logic [7:0]    rdata_q;
	logic          ren;
	logic [AW-1:0] raddr;
	logic          wen;

	// result register
	logic          out_valid_q;
	kind_t         kind_q;
	logic [31:0]   frame_offset_q;
	logic [7:0]    payload_q;
	logic          last_q;
	logic          more_q;
	logic [31:0]   total_q;
	logic [31:0]   oldest_q;
	logic [31:0]   conf_out_q;

	logic          accept;
	logic          can_emit;
	logic          emit;        // result register loads this cycle
	logic [31:0]   oldest;
	logic [31:0]   backlog;     // wc_q - cursor_q
	logic [CW-1:0] got;
	logic [AW+1:0] back_diff;
	logic [AW-1:0] first_addr;
	logic [AW-1:0] addr_inc;
	logic [AW-1:0] wptr_inc;
	logic          caught_up;
	logic          behind;
	logic [31:0]   stat_cursor;
	logic          stat_more;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign can_emit = !out_valid_q || out_ready;
	assign wen      = accept && (mode == MODE_APPEND);

	// oldest offset still held in the ring
	assign oldest    = (wc_q > 32'(CAPACITY)) ? (wc_q - 32'(CAPACITY)) : '0;
	assign caught_up = (cursor_q >= wc_q);
	assign behind    = (cursor_q < oldest);
	assign backlog   = wc_q - cursor_q;
	assign got       = (backlog > 32'(CHUNK)) ? CW'(CHUNK) : backlog[CW-1:0];

	assign emit = can_emit && ((state_q == S_LOST) || (state_q == S_CMDST) ||
		(state_q == S_DATA) || (state_q == S_TAIL) ||
		((state_q == S_EVAL) && sending_q && (caught_up || behind)));

	// Cursor sits in [oldest, wc), so backlog <= CAPACITY and its ring slot is
	// the write pointer stepped back by backlog, with one wrap at most.
	assign back_diff  = {2'b00, wptr_q} - {1'b0, backlog[AW:0]};
	assign first_addr = back_diff[AW+1] ? AW'(back_diff + (AW+2)'(CAPACITY))
	                                    : back_diff[AW-1:0];

	assign addr_inc = (addr_q == AW'(CAPACITY - 1)) ? '0 : addr_q + AW'(1);
	// 32-bit wrap of the byte count restarts the slot numbering, as offsets do
	assign wptr_inc = ((wc_q == '1) || (wptr_q == AW'(CAPACITY - 1))) ? '0
	                  : wptr_q + AW'(1);

	// lost history moves the cursor to the oldest byte before reporting
	assign stat_cursor = (state_q == S_EVAL && behind) ? oldest : cursor_q;
	assign stat_more   = (stat_cursor < wc_q);

	always_comb begin
		ren   = 1'b0;
		raddr = addr_inc;
		unique case (state_q)
			S_EVAL: begin
				if (sending_q && !caught_up && !behind) begin
					ren   = 1'b1;
					raddr = first_addr;
				end
			end
			S_DATA: begin
				ren   = can_emit && (cnt_q != CW'(1));
				raddr = addr_inc;
			end
			default: begin
				ren = 1'b0;
			end
		endcase
	end

	// ring RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wen) begin
			ring_mem[wptr_q] <= data_byte;
		end
		if (ren) begin
			rdata_q <= ring_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wc_q           <= '0;
			wptr_q         <= '0;
			cursor_q       <= '0;
			conf_q         <= '0;
			sending_q      <= 1'b0;
			conn_q         <= 1'b0;
			start_q        <= '0;
			cnt_q          <= '0;
			addr_q         <= '0;
			tail_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			kind_q         <= KIND_DATA;
			frame_offset_q <= '0;
			payload_q      <= '0;
			last_q         <= 1'b0;
			more_q         <= 1'b0;
			total_q        <= '0;
			oldest_q       <= '0;
			conf_out_q     <= '0;
		end else begin
			if (out_valid_q && out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_APPEND) begin
							wc_q   <= wc_q + 32'd1;
							wptr_q <= wptr_inc;
						end else if (!link_up) begin
							if (conn_q) begin
								conn_q    <= 1'b0;
								sending_q <= 1'b0;
								state_q   <= S_LOST;
							end
						end else begin
							conn_q <= 1'b1;
							if (command_valid) begin
								case (cmd_t'(command))
									CMD_SEEK: begin
										cursor_q  <= argument;
										sending_q <= 1'b1;
									end
									CMD_ACK: begin
										if (argument > conf_q) begin
											conf_q <= argument;
										end
									end
									CMD_STOP: begin
										sending_q <= 1'b0;
									end
									default: begin
									end
								endcase
								state_q <= S_CMDST;
							end else begin
								state_q <= S_EVAL;
							end
						end
					end
				end

				S_LOST: begin
					if (can_emit) begin
						out_valid_q    <= 1'b1;
						kind_q         <= KIND_LOST;
						frame_offset_q <= '0;
						payload_q      <= '0;
						last_q         <= 1'b1;
						more_q         <= 1'b0;
						total_q        <= '0;
						oldest_q       <= '0;
						conf_out_q     <= '0;
						state_q        <= S_IDLE;
					end
				end

				S_CMDST: begin
					// status answering a command; last unless sending, when a further result follows
					if (can_emit) begin
						out_valid_q    <= 1'b1;
						kind_q         <= KIND_STATUS;
						frame_offset_q <= '0;
						payload_q      <= '0;
						last_q         <= !sending_q;
						more_q         <= stat_more;
						total_q        <= wc_q;
						oldest_q       <= oldest;
						conf_out_q     <= conf_q;
						state_q        <= S_EVAL;
					end
				end

				S_EVAL: begin
					if (!sending_q) begin
						state_q <= S_IDLE;
					end else if (caught_up || behind) begin
						if (can_emit) begin
							if (caught_up) begin
								sending_q <= 1'b0;
							end else begin
								cursor_q <= oldest;
							end
							out_valid_q    <= 1'b1;
							kind_q         <= KIND_STATUS;
							frame_offset_q <= '0;
							payload_q      <= '0;
							last_q         <= 1'b1;
							more_q         <= stat_more;
							total_q        <= wc_q;
							oldest_q       <= oldest;
							conf_out_q     <= conf_q;
							state_q        <= S_IDLE;
						end
					end else begin
						// first byte read issued this cycle
						start_q  <= cursor_q;
						cnt_q    <= got;
						addr_q   <= first_addr;
						tail_q   <= (backlog <= 32'(CHUNK));
						cursor_q <= cursor_q + 32'(got);
						state_q  <= S_DATA;
					end
				end

				S_DATA: begin
					if (can_emit) begin
						out_valid_q    <= 1'b1;
						kind_q         <= KIND_DATA;
						frame_offset_q <= start_q;
						payload_q      <= rdata_q;
						last_q         <= (cnt_q == CW'(1)) && !tail_q;
						more_q         <= 1'b0;
						total_q        <= '0;
						oldest_q       <= '0;
						conf_out_q     <= '0;
						if (cnt_q == CW'(1)) begin
							state_q <= tail_q ? S_TAIL : S_IDLE;
						end else begin
							cnt_q  <= cnt_q - CW'(1);
							addr_q <= addr_inc;
						end
					end
				end

				S_TAIL: begin
					if (can_emit) begin
						out_valid_q    <= 1'b1;
						kind_q         <= KIND_STATUS;
						frame_offset_q <= '0;
						payload_q      <= '0;
						last_q         <= 1'b1;
						more_q         <= stat_more;
						total_q        <= wc_q;
						oldest_q       <= oldest;
						conf_out_q     <= conf_q;
						state_q        <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign frame_offset     = frame_offset_q;
	assign payload_byte     = payload_q;
	assign last             = last_q;
	assign more_pending     = more_q;
	assign total_bytes      = total_q;
	assign oldest_offset    = oldest_q;
	assign confirmed_offset = conf_out_q;

	// write pointer stays inside the ring
	a_wptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= AW'(CAPACITY - 1))
		else $error("write pointer outside ring");

	// a chunk walk always has a byte left and runs only while sending
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> (cnt_q != '0) && sending_q)
		else $error("chunk walk with no byte left or not sending");

	// link-lost result closes its poll
	a_lost_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_LOST) |-> last_q)
		else $error("link-lost result without last");

	// after a chunk's closing status the cursor has caught up
	a_tail_caught: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL && can_emit) |=> (out_valid_q && !more_q))
		else $error("closing status reports pending bytes");

endmodule
